[hw/rtl/uer_pkg.sv]
package uer_pkg;

  // Default width of the elapsed-tick and poll counters.
  localparam int unsigned COUNT_WIDTH = 24;

  localparam int unsigned TIMEOUT_W  = 24;
  localparam int unsigned POLL_W     = 24;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PULSE_W    = 24;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned REM_W      = 11;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd38000;
  localparam logic [POLL_W-1:0]    POLL_RESET    = 24'hFF_FFFF;
  localparam logic [TRIG_W-1:0]    TRIG_RESET    = 8'd10;

  // Distance is (pulse * DIST_STEP + DIST_BIAS) / DIST_DIV, tracked one tick at a time.
  localparam logic [REM_W:0]   DIST_STEP = 12'd343;
  localparam logic [REM_W:0]   DIST_DIV  = 12'd2000;
  localparam logic [REM_W-1:0] DIST_BIAS = 11'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECHO_TIMEOUT = 2'd0,
    CFG_POLL_LIMIT   = 2'd1,
    CFG_TRIG_WIDTH   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_LOW  = 3'd1,
    PH_TRIGGER   = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_WAIT_FALL = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_LOW  = 3'd1,
    ST_RISE_TO  = 3'd2,
    ST_FALL_TO  = 3'd3,
    ST_POLLS    = 3'd4,
    ST_BOUNDS   = 3'd5
  } status_e;

  typedef struct packed {
    logic                 valid;
    logic                 action;
    logic                 echo;
  } step_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] echo_timeout;
    logic [POLL_W-1:0]    poll_limit;
    logic [TRIG_W-1:0]    trig_width;
  } cfg_t;

  typedef struct packed {
    logic                 trigger;
    logic                 busy;
    logic                 done;
    status_e              status;
    logic [PULSE_W-1:0]   pulse;
    logic [DIST_W-1:0]    dist_mm;
  } result_t;

endpackage

[hw/rtl/uer_core.sv]
module uer_core #(
  parameter int unsigned CountWidth = uer_pkg::COUNT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uer_pkg::step_t   step_i,
  input  uer_pkg::cfg_t    cfg_i,
  output uer_pkg::result_t result_o
);

  localparam int unsigned CmpW =
    (CountWidth > uer_pkg::TIMEOUT_W) ? CountWidth : uer_pkg::TIMEOUT_W;

  uer_pkg::phase_e                 phase_q, phase_d;
  logic [CountWidth-1:0]           elapsed_q, elapsed_d;
  logic [CountWidth-1:0]           polls_q, polls_d;
  logic [uer_pkg::TRIG_W-1:0]      trig_ticks_q, trig_ticks_d;
  logic                            trig_q, trig_d;
  logic [uer_pkg::DIST_W-1:0]      dist_quo_q, dist_quo_d;
  logic [uer_pkg::REM_W-1:0]       dist_rem_q, dist_rem_d;

  logic                            tick, start;
  logic                            elapsed_sat;
  logic [CountWidth-1:0]           elapsed_inc, polls_inc;
  logic [CmpW-1:0]                 elapsed_ext, polls_ext;
  logic                            want_level, echo_match;
  logic                            timed_out, poll_hit, wait_fail;
  logic [uer_pkg::TRIG_W-1:0]      trig_ticks_inc;
  logic [uer_pkg::REM_W:0]         rem_sum;
  logic                            rem_wrap;
  logic [uer_pkg::REM_W-1:0]       rem_next;
  logic [uer_pkg::DIST_W-1:0]      quo_next;
  logic                            done;
  uer_pkg::status_e                status;
  logic [uer_pkg::PULSE_W-1:0]     pulse;
  logic [uer_pkg::DIST_W-1:0]      distance;

  assign tick  = step_i.valid && !step_i.action;
  assign start = step_i.valid && step_i.action;

  // Shared wait-phase poll: saturating counters and the two limit checks.
  assign elapsed_sat = (elapsed_q == {CountWidth{1'b1}});
  assign elapsed_inc = elapsed_sat ? elapsed_q : elapsed_q + 1'b1;
  assign polls_inc   = (polls_q == {CountWidth{1'b1}}) ? polls_q : polls_q + 1'b1;
  assign elapsed_ext = CmpW'(elapsed_inc);
  assign polls_ext   = CmpW'(polls_inc);
  assign want_level  = (phase_q == uer_pkg::PH_WAIT_RISE);
  assign echo_match  = (step_i.echo == want_level);
  assign timed_out   = (elapsed_ext >= CmpW'(cfg_i.echo_timeout));
  assign poll_hit    = (polls_ext >= CmpW'(cfg_i.poll_limit));
  assign wait_fail   = !echo_match && (timed_out || poll_hit);

  assign trig_ticks_inc = (trig_ticks_q == {uer_pkg::TRIG_W{1'b1}}) ?
                          trig_ticks_q : trig_ticks_q + 1'b1;

  // The distance quotient and remainder follow the elapsed count of the fall
  // phase, so the division by the constant reduces to one add and compare.
  assign rem_sum  = {1'b0, dist_rem_q} + uer_pkg::DIST_STEP;
  assign rem_wrap = (rem_sum >= uer_pkg::DIST_DIV);
  always_comb begin
    rem_next = dist_rem_q;
    quo_next = dist_quo_q;
    if (!elapsed_sat) begin
      rem_next = rem_wrap ? uer_pkg::REM_W'(rem_sum - uer_pkg::DIST_DIV)
                          : rem_sum[uer_pkg::REM_W-1:0];
      if (rem_wrap && (dist_quo_q != {uer_pkg::DIST_W{1'b1}})) begin
        quo_next = dist_quo_q + 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    polls_d      = polls_q;
    trig_ticks_d = trig_ticks_q;
    trig_d       = trig_q;
    dist_quo_d   = dist_quo_q;
    dist_rem_d   = dist_rem_q;
    if (start) begin
      if (phase_q == uer_pkg::PH_IDLE) begin
        phase_d      = uer_pkg::PH_WAIT_LOW;
        elapsed_d    = '0;
        polls_d      = '0;
        trig_ticks_d = '0;
        trig_d       = 1'b0;
      end
    end else if (tick) begin
      unique case (phase_q)
        uer_pkg::PH_IDLE: begin
        end
        uer_pkg::PH_WAIT_LOW: begin
          if (echo_match) begin
            phase_d      = uer_pkg::PH_TRIGGER;
            elapsed_d    = '0;
            polls_d      = '0;
            trig_ticks_d = '0;
            trig_d       = 1'b1;
          end else if (wait_fail) begin
            phase_d      = uer_pkg::PH_IDLE;
            elapsed_d    = '0;
            polls_d      = '0;
            trig_ticks_d = '0;
            trig_d       = 1'b0;
          end else begin
            elapsed_d = elapsed_inc;
            polls_d   = polls_inc;
          end
        end
        uer_pkg::PH_TRIGGER: begin
          if (trig_ticks_inc >= cfg_i.trig_width) begin
            phase_d      = uer_pkg::PH_WAIT_RISE;
            elapsed_d    = '0;
            polls_d      = '0;
            trig_ticks_d = trig_ticks_inc;
            trig_d       = 1'b0;
          end else begin
            trig_ticks_d = trig_ticks_inc;
          end
        end
        uer_pkg::PH_WAIT_RISE: begin
          if (echo_match) begin
            phase_d    = uer_pkg::PH_WAIT_FALL;
            elapsed_d  = '0;
            polls_d    = '0;
            dist_quo_d = '0;
            dist_rem_d = uer_pkg::DIST_BIAS;
          end else if (wait_fail) begin
            phase_d      = uer_pkg::PH_IDLE;
            elapsed_d    = '0;
            polls_d      = '0;
            trig_ticks_d = '0;
            trig_d       = 1'b0;
          end else begin
            elapsed_d = elapsed_inc;
            polls_d   = polls_inc;
          end
        end
        uer_pkg::PH_WAIT_FALL: begin
          if (echo_match || wait_fail) begin
            phase_d      = uer_pkg::PH_IDLE;
            elapsed_d    = '0;
            polls_d      = '0;
            trig_ticks_d = '0;
            trig_d       = 1'b0;
          end else begin
            elapsed_d  = elapsed_inc;
            polls_d    = polls_inc;
            dist_rem_d = rem_next;
            dist_quo_d = quo_next;
          end
        end
        default: begin
          phase_d = uer_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result of the current transaction.
  always_comb begin
    done     = 1'b0;
    status   = uer_pkg::ST_OK;
    pulse    = '0;
    distance = '0;
    if (tick) begin
      unique case (phase_q)
        uer_pkg::PH_WAIT_LOW: begin
          if (wait_fail) begin
            done   = 1'b1;
            status = timed_out ? uer_pkg::ST_NOT_LOW : uer_pkg::ST_POLLS;
          end
        end
        uer_pkg::PH_WAIT_RISE: begin
          if (wait_fail) begin
            done   = 1'b1;
            status = timed_out ? uer_pkg::ST_RISE_TO : uer_pkg::ST_POLLS;
          end
        end
        uer_pkg::PH_WAIT_FALL: begin
          if (echo_match) begin
            done = 1'b1;
            if ((elapsed_ext == '0) || timed_out) begin
              status = uer_pkg::ST_BOUNDS;
            end else begin
              pulse    = elapsed_ext[uer_pkg::PULSE_W-1:0];
              distance = quo_next;
            end
          end else if (wait_fail) begin
            done   = 1'b1;
            status = timed_out ? uer_pkg::ST_FALL_TO : uer_pkg::ST_POLLS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_o.trigger = trig_d;
  assign result_o.busy    = (phase_d != uer_pkg::PH_IDLE);
  assign result_o.done    = done;
  assign result_o.status  = status;
  assign result_o.pulse   = pulse;
  assign result_o.dist_mm = distance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= uer_pkg::PH_IDLE;
      elapsed_q    <= '0;
      polls_q      <= '0;
      trig_ticks_q <= '0;
      trig_q       <= 1'b0;
      dist_quo_q   <= '0;
      dist_rem_q   <= '0;
    end else begin
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      polls_q      <= polls_d;
      trig_ticks_q <= trig_ticks_d;
      trig_q       <= trig_d;
      dist_quo_q   <= dist_quo_d;
      dist_rem_q   <= dist_rem_d;
    end
  end

endmodule

[hw/rtl/ultrasonic_echo_ranger.sv]
// A transaction waits in the input register and its result is registered at the output.
// One transaction per cycle while the result register is free or drains; the sequencer state
// advances as an item leaves the input register, and the result register holds it until taken.
// Reset (asynchronous, active low) returns the sequencer to idle, clears the
// counters and loads the registers with 38000, 16777215 and 10.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_WIDTH = uer_pkg::COUNT_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic                               echo_level_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               trigger_out_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [2:0]                         status_o,
  output logic [uer_pkg::PULSE_W-1:0]        pulse_width_us_o,
  output logic [uer_pkg::DIST_W-1:0]         distance_mm_o
);

  uer_pkg::cfg_t    cfg_q;
  logic             in_valid_q;
  logic             action_q;
  logic             echo_q;
  logic             out_valid_q;
  uer_pkg::result_t res_q;
  uer_pkg::result_t result;
  uer_pkg::step_t   step;
  logic             advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_timeout <= uer_pkg::TIMEOUT_RESET;
      cfg_q.poll_limit   <= uer_pkg::POLL_RESET;
      cfg_q.trig_width   <= uer_pkg::TRIG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uer_pkg::CFG_ECHO_TIMEOUT: cfg_q.echo_timeout <= cfg_data_i;
        uer_pkg::CFG_POLL_LIMIT:   cfg_q.poll_limit   <= cfg_data_i;
        uer_pkg::CFG_TRIG_WIDTH:   cfg_q.trig_width   <= cfg_data_i[uer_pkg::TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input register moves on whenever the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign step.valid  = advance;
  assign step.action = action_q;
  assign step.echo   = echo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= action_i;
      echo_q   <= echo_level_i;
    end
  end

  uer_core #(
    .CountWidth(COUNT_WIDTH)
  ) u_core (
    .clk_i,
    .rst_ni,
    .step_i   (step),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_out_o    = res_q.trigger;
  assign busy_res_o       = res_q.busy;
  assign done_res_o       = res_q.done;
  assign status_o         = res_q.status;
  assign pulse_width_us_o = res_q.pulse;
  assign distance_mm_o    = res_q.dist_mm;

endmodule

[verif/echo_ranger_checker.sv]
`timescale 1ns / 100ps

package ranger_tb_pkg;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } action_e;

endpackage

module echo_ranger_checker
  import uer_pkg::*;
  import ranger_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 action_i,
  input  logic                 echo_level_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 trigger_out_i,
  input  logic                 busy_res_i,
  input  logic                 done_res_i,
  input  logic [2:0]           status_i,
  input  logic [PULSE_W-1:0]   pulse_width_us_i,
  input  logic [DIST_W-1:0]    distance_mm_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  // Sequencer copy kept in step with every accepted transaction.
  logic [TIMEOUT_W-1:0]   timeout_reg;
  logic [POLL_W-1:0]      poll_reg;
  logic [TRIG_W-1:0]      trig_reg;
  phase_e                 phase;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic [COUNT_WIDTH-1:0] polls;
  logic [TRIG_W-1:0]      trig_ticks;
  logic                   trig_level;

  result_t                expected_readings[$];
  result_t                expected_res;
  int unsigned            mismatches;

  assign mismatch_count_o = mismatches;

  function automatic void enter_phase(input phase_e next);
    phase = next;
    elapsed = '0;
    polls = '0;
  endfunction

  // Returns 1 when the awaited level is seen; flags a timeout or a poll-limit trip.
  function automatic logic poll_echo(input logic echo, input logic want,
                                     input status_e fail_status,
                                     output logic failed, output status_e code);
    failed = 1'b0;
    code = ST_OK;
    if (elapsed != '1) elapsed++;
    if (echo == want) return 1'b1;
    if (elapsed >= timeout_reg) begin
      failed = 1'b1;
      code = fail_status;
    end else begin
      if (polls != '1) polls++;
      if (polls >= poll_reg) begin
        failed = 1'b1;
        code = ST_POLLS;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_sequencer(input logic action, input logic echo);
    result_t     r;
    logic        matched;
    logic        failed;
    status_e     code;
    logic [63:0] dist_full;
    r = '0;
    r.status = ST_OK;
    if (action == ACT_START) begin
      if (phase == PH_IDLE) begin
        enter_phase(PH_WAIT_LOW);
        trig_ticks = '0;
        trig_level = 1'b0;
      end
    end else begin
      case (phase)
        PH_WAIT_LOW: begin
          matched = poll_echo(echo, 1'b0, ST_NOT_LOW, failed, code);
          if (matched) begin
            enter_phase(PH_TRIGGER);
            trig_ticks = '0;
            trig_level = 1'b1;
          end else if (failed) begin
            r.done = 1'b1;
            r.status = code;
          end
        end
        PH_TRIGGER: begin
          if (trig_ticks != '1) trig_ticks++;
          if (trig_ticks >= trig_reg) begin
            trig_level = 1'b0;
            enter_phase(PH_WAIT_RISE);
          end
        end
        PH_WAIT_RISE: begin
          matched = poll_echo(echo, 1'b1, ST_RISE_TO, failed, code);
          if (matched) begin
            enter_phase(PH_WAIT_FALL);
          end else if (failed) begin
            r.done = 1'b1;
            r.status = code;
          end
        end
        PH_WAIT_FALL: begin
          matched = poll_echo(echo, 1'b0, ST_FALL_TO, failed, code);
          if (matched) begin
            r.done = 1'b1;
            if (elapsed == '0 || elapsed >= timeout_reg) begin
              r.status = ST_BOUNDS;
            end else begin
              r.pulse = PULSE_W'(elapsed);
              dist_full = (64'(elapsed) * DIST_STEP + DIST_BIAS) / DIST_DIV;
              r.dist_mm = (dist_full > {DIST_W{1'b1}}) ? {DIST_W{1'b1}}
                                                       : dist_full[DIST_W-1:0];
            end
          end else if (failed) begin
            r.done = 1'b1;
            r.status = code;
          end
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
      if (r.done) begin
        enter_phase(PH_IDLE);
        trig_ticks = '0;
        trig_level = 1'b0;
      end
    end
    r.trigger = trig_level;
    r.busy = (phase != PH_IDLE);
    return r;
  endfunction

  task automatic compare_field(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_reg = TIMEOUT_RESET;
      poll_reg = POLL_RESET;
      trig_reg = TRIG_RESET;
      phase = PH_IDLE;
      elapsed = '0;
      polls = '0;
      trig_ticks = '0;
      trig_level = 1'b0;
      mismatches = 0;
      expected_readings.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ECHO_TIMEOUT: timeout_reg = cfg_data_i[TIMEOUT_W-1:0];
          CFG_POLL_LIMIT:   poll_reg = cfg_data_i[POLL_W-1:0];
          CFG_TRIG_WIDTH:   trig_reg = cfg_data_i[TRIG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_readings.push_back(advance_sequencer(action_i, echo_level_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual trigger %0b busy %0b done %0b",
                   $time, trigger_out_i, busy_res_i, done_res_i);
          $display("%0t:   status %0d pulse %0d distance %0d",
                   $time, status_i, pulse_width_us_i, distance_mm_i);
          mismatches++;
        end else begin
          expected_res = expected_readings.pop_front();
          compare_field("trigger", expected_res.trigger, trigger_out_i);
          compare_field("busy", expected_res.busy, busy_res_i);
          compare_field("done", expected_res.done, done_res_i);
          compare_field("status", expected_res.status, status_i);
          compare_field("pulse width", expected_res.pulse, pulse_width_us_i);
          compare_field("distance", expected_res.dist_mm, distance_mm_i);
        end
      end
      pending_o <= expected_readings.size();
    end
  end

endmodule

[verif/ultrasonic_echo_ranger_tb.sv]
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;
  import ranger_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASE_ITEMS    = 40;
  localparam logic [CFG_DATA_W-1:0] REG_MAX = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  cfg_idx_e               cfg_idx = CFG_ECHO_TIMEOUT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  action_e                action = ACT_TICK;
  logic                   echo = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   trigger_out;
  logic                   busy_res;
  logic                   done_res;
  logic [2:0]             status;
  logic [PULSE_W-1:0]     pulse_width;
  logic [DIST_W-1:0]      distance;

  int unsigned            error_count;
  int unsigned            pending;
  int unsigned            stalled_cycles = 0;
  int unsigned            items_sent = 0;
  int unsigned            sender_idle_pct = 0;
  int unsigned            stall_pct = 0;
  logic                   hold_request = 1'b0;
  logic [TRIG_W-1:0]      cur_trig = TRIG_RESET;

  always #5 clk = ~clk;

  ultrasonic_echo_ranger DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .echo_level_i     (echo),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .trigger_out_o    (trigger_out),
    .busy_res_o       (busy_res),
    .done_res_o       (done_res),
    .status_o         (status),
    .pulse_width_us_o (pulse_width),
    .distance_mm_o    (distance)
  );

  echo_ranger_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .echo_level_i     (echo),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .trigger_out_i    (trigger_out),
    .busy_res_i       (busy_res),
    .done_res_i       (done_res),
    .status_i         (status),
    .pulse_width_us_i (pulse_width),
    .distance_mm_i    (distance),
    .mismatch_count_o (error_count),
    .pending_o        (pending)
  );

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input action_e act, input logic level);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    echo <= level;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // A tick, sometimes preceded by a start that the busy sequencer must ignore.
  task automatic send_tick(input logic level, input int unsigned busy_start_pct);
    if ($urandom_range(99) < busy_start_pct) send_item(ACT_START, 1'($urandom_range(1)));
    send_item(ACT_TICK, level);
  endtask

  // Waits until every result has drained, then loads all three registers.
  task automatic write_regs(input logic [CFG_DATA_W-1:0] timeout_val,
                            input logic [CFG_DATA_W-1:0] poll_val,
                            input logic [CFG_DATA_W-1:0] trig_val);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_ECHO_TIMEOUT;
    cfg_data <= timeout_val;
    @(posedge clk);
    cfg_idx <= CFG_POLL_LIMIT;
    cfg_data <= poll_val;
    @(posedge clk);
    cfg_idx <= CFG_TRIG_WIDTH;
    cfg_data <= trig_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_trig = trig_val[TRIG_W-1:0];
  endtask

  // One well-formed measurement: echo high for a while, low to fire the trigger,
  // the trigger ticks, a gap before the rise, the pulse, then the fall.
  task automatic measure(input int unsigned pre_high, input int unsigned rise_gap,
                         input int unsigned pulse_len, input int unsigned busy_start_pct);
    send_item(ACT_START, 1'($urandom_range(1)));
    repeat (pre_high) send_tick(1'b1, busy_start_pct);
    send_tick(1'b0, busy_start_pct);
    repeat ((cur_trig == 0) ? 1 : cur_trig) send_tick(1'($urandom_range(1)), busy_start_pct);
    repeat (rise_gap) send_tick(1'b0, busy_start_pct);
    send_tick(1'b1, busy_start_pct);
    repeat (pulse_len) send_tick(1'b1, busy_start_pct);
    send_tick(1'b0, busy_start_pct);
  endtask

  initial begin
    int unsigned           base_count;
    logic [CFG_DATA_W-1:0] timeout_val;
    logic [CFG_DATA_W-1:0] poll_val;
    logic [CFG_DATA_W-1:0] trig_val;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: ticks while idle, then a start followed by a second one while busy.
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_START, 1'b1);
    measure(1, 1, 3, 0);

    // Short timeout with a zero trigger width: echo never low, rise and fall timeouts.
    write_regs(CFG_DATA_W'(2), REG_MAX, '0);
    measure(3, 0, 0, 0);
    measure(0, 5, 0, 0);
    measure(0, 0, 4, 0);

    // A pulse as long as the timeout is out of bounds.
    write_regs(CFG_DATA_W'(1), REG_MAX, CFG_DATA_W'(1));
    measure(0, 0, 0, 0);

    // Zero poll limit and zero timeout both fail at the first mismatching poll.
    write_regs(REG_MAX, '0, CFG_DATA_W'(1));
    measure(1, 0, 0, 0);
    write_regs('0, CFG_DATA_W'(3), CFG_DATA_W'(1));
    measure(1, 0, 0, 0);
    write_regs(REG_MAX, CFG_DATA_W'(2), CFG_DATA_W'(1));
    measure(0, 3, 2, 0);

    // A long pulse with every limit at its maximum.
    write_regs(REG_MAX, REG_MAX, CFG_DATA_W'(1));
    measure(0, 0, 40, 0);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 67; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 67; end
        default: begin sender_idle_pct = 11; stall_pct = 11; end
      endcase
      timeout_val = ($urandom_range(3) == 0) ? REG_MAX : CFG_DATA_W'($urandom_range(30, 1));
      poll_val = ($urandom_range(2) == 0) ? CFG_DATA_W'($urandom_range(8)) : REG_MAX;
      trig_val = CFG_DATA_W'($urandom());
      trig_val[TRIG_W-1:0] = (p == 5) ? '1 : TRIG_W'($urandom_range(5));
      write_regs(timeout_val, poll_val, trig_val);
      if (p == 4) hold_request = 1'b1;
      base_count = items_sent;
      while (items_sent - base_count < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(6, 1)) begin
            send_item(action_e'($urandom_range(1)), 1'($urandom_range(1)));
          end
        end else begin
          measure(($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0,
                  $urandom_range(8), $urandom_range(30), 5);
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/uer_pkg.sv
hw/rtl/uer_core.sv
hw/rtl/ultrasonic_echo_ranger.sv
verif/echo_ranger_checker.sv
verif/ultrasonic_echo_ranger_tb.sv
